// ===== hdl/mtf_pkg.sv =====
package mtf_pkg;

  localparam int unsigned LIST_DEPTH_DEF  = 16;
  localparam int unsigned IDENT_WIDTH_DEF = 32;

  // Widths of the capacity register and of the fixed result fields.
  localparam int unsigned CAP_W = 5;
  localparam int unsigned POS_W = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Control handed from the top level to one cell.
  typedef struct packed {
    logic load;      // take the neighbor's entry (or the new word in cell 0)
    logic in_range;  // cell lies below the valid count
  } cell_ctrl_t;

  // Status rippled along the chain from the front to the back.
  typedef struct packed {
    logic found;  // some cell at or ahead of this one matched
    logic first;  // this cell holds the first match
  } cell_stat_t;

endpackage

// ===== hdl/mtf_in_if.sv =====
interface mtf_in_if #(
  parameter int unsigned IDENT_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [IDENT_WIDTH-1:0] ident;

  modport source (output valid, output ident, input ready);
  modport sink   (input valid, input ident, output ready);
endinterface

// ===== hdl/mtf_out_if.sv =====
interface mtf_out_if #(
  parameter int unsigned IDENT_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [3:0]             hit_position;
  logic [4:0]             entry_count;
  logic                   evicted_valid;
  logic [IDENT_WIDTH-1:0] evicted_ident;

  modport source (output valid, output hit, output hit_position, output entry_count,
                  output evicted_valid, output evicted_ident, input ready);
  modport sink   (input valid, input hit, input hit_position, input entry_count,
                  input evicted_valid, input evicted_ident, output ready);
endinterface

// ===== hdl/move_to_front_recency_list_core.sv =====
// Move-to-front recency list. Each accepted word carries one identifier; the
// block answers with one result word telling whether the identifier was
// already listed, where it stood, the new entry count and any identifier that
// fell off the back of a full list. For each accepted word, one
// row of LIST_DEPTH cells compares all entries at once, the match ripples down
// the chain, and every cell at or ahead of the shift point takes its front
// neighbor's entry at the same clock edge. The result sits in an output
// register, so one word per cycle is sustained while the sink keeps taking
// results. Capacity writes take effect from the next word on; a capacity
// below the current count trims the list silently.
module move_to_front_recency_list_core import mtf_pkg::*; #(
  parameter int unsigned LIST_DEPTH  = LIST_DEPTH_DEF,
  parameter int unsigned IDENT_WIDTH = IDENT_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  mtf_in_if.sink           in_chan_i,
  mtf_out_if.source        out_chan_o
);

  localparam int unsigned CMP_W = 7;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(LIST_DEPTH);

  logic [CAP_W-1:0] cap_q, cap_d;
  logic [CAP_W-1:0] count_q, count_d;
  logic [CAP_W-1:0] cap_eff, count_eff, top, pos, count_next;
  logic             accept, found, full, evict;

  logic [IDENT_WIDTH-1:0] entry   [LIST_DEPTH];
  logic [IDENT_WIDTH-1:0] prev    [LIST_DEPTH];
  logic [IDENT_WIDTH-1:0] ev_term [LIST_DEPTH];
  logic [CAP_W-1:0]       pos_term[LIST_DEPTH];
  cell_ctrl_t             ctrl    [LIST_DEPTH];
  cell_stat_t             stat    [LIST_DEPTH];
  logic                   found_in[LIST_DEPTH];

  logic                   out_valid_q;
  logic                   hit_q, hit_d;
  logic [POS_W-1:0]       hpos_q, hpos_d;
  logic [CAP_W-1:0]       ocount_q;
  logic                   ev_valid_q;
  logic [IDENT_WIDTH-1:0] ev_ident_q, ev_ident_d;

  assign in_chan_i.ready = !out_valid_q || out_chan_o.ready;
  assign accept          = in_chan_i.valid && in_chan_i.ready;

  always_comb begin
    cap_eff = cap_q;
    if (cap_q == '0) begin
      cap_eff = CAP_W'(1);
    end else if ({{(CMP_W-CAP_W){1'b0}}, cap_q} > DEPTH_C) begin
      cap_eff = CAP_W'(LIST_DEPTH);
    end
    count_eff = (count_q > cap_eff) ? cap_eff : count_q;
  end

  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      localparam logic [CMP_W-1:0] IDX = CMP_W'(gi);
      if (gi == 0) begin : g_front
        assign prev[gi]     = in_chan_i.ident;
        assign found_in[gi] = 1'b0;
      end else begin : g_rest
        assign prev[gi]     = entry[gi-1];
        assign found_in[gi] = stat[gi-1].found;
      end
      assign ctrl[gi].load     = accept && (IDX <= {{(CMP_W-CAP_W){1'b0}}, top});
      assign ctrl[gi].in_range = IDX < {{(CMP_W-CAP_W){1'b0}}, count_eff};
      assign pos_term[gi] = stat[gi].first ? CAP_W'(gi) : '0;
      assign ev_term[gi]  =
        (IDX == {{(CMP_W-CAP_W){1'b0}}, cap_eff - CAP_W'(1)}) ? entry[gi] : '0;

      mtf_cell #(
        .IDENT_WIDTH(IDENT_WIDTH)
      ) u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl[gi]),
        .ident_i     (in_chan_i.ident),
        .prev_entry_i(prev[gi]),
        .found_i     (found_in[gi]),
        .entry_o     (entry[gi]),
        .stat_o      (stat[gi])
      );
    end
  endgenerate

  always_comb begin
    found = stat[LIST_DEPTH-1].found;
    pos   = '0;
    ev_ident_d = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      pos        = pos | pos_term[i];
      ev_ident_d = ev_ident_d | ev_term[i];
    end
    full  = (count_eff == cap_eff);
    evict = !found && full;
    if (!evict) begin
      ev_ident_d = '0;
    end
    if (found) begin
      top = pos;
    end else if (!full) begin
      top = count_eff;
    end else begin
      top = cap_eff - CAP_W'(1);
    end
    count_next = (!found && !full) ? count_eff + CAP_W'(1) : count_eff;
    hit_d  = found;
    hpos_d = pos[POS_W-1:0];
  end

  always_comb begin
    cap_d   = cfg_we_i ? cfg_wdata_i : cap_q;
    count_d = accept ? count_next : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q   <= cap_d;
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q      <= hit_d;
      hpos_q     <= hpos_d;
      ocount_q   <= count_next;
      ev_valid_q <= evict;
      ev_ident_q <= ev_ident_d;
    end
  end

  assign out_chan_o.valid         = out_valid_q;
  assign out_chan_o.hit           = hit_q;
  assign out_chan_o.hit_position  = hpos_q;
  assign out_chan_o.entry_count   = ocount_q;
  assign out_chan_o.evicted_valid = ev_valid_q;
  assign out_chan_o.evicted_ident = ev_ident_q;

  // The stored count never passes the built depth.
  a_count_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{(CMP_W-CAP_W){1'b0}}, count_q} <= DEPTH_C)
    else $error("entry count beyond list depth");

  // A hit lies inside the list that remains after the step.
  a_hit_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && found |-> pos < count_next)
    else $error("hit position outside the valid entries");

  // A miss always leaves at least one entry behind.
  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !found |=> count_q != '0)
    else $error("miss left the list empty");

  // Only a miss reports a dropped entry.
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ev_valid_q |-> !hit_q)
    else $error("eviction reported together with a hit");

endmodule

// ===== hdl/mtf_cell.sv =====
module mtf_cell import mtf_pkg::*; #(
  parameter int unsigned IDENT_WIDTH = IDENT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic [IDENT_WIDTH-1:0] ident_i,
  input  logic [IDENT_WIDTH-1:0] prev_entry_i,
  input  logic                   found_i,
  output logic [IDENT_WIDTH-1:0] entry_o,
  output cell_stat_t             stat_o
);

  logic [IDENT_WIDTH-1:0] entry_q;
  logic [IDENT_WIDTH-1:0] entry_d;
  logic                   match;

  assign match        = ctrl_i.in_range && (entry_q == ident_i);
  assign stat_o.found = found_i || match;
  assign stat_o.first = match && !found_i;
  assign entry_o      = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = prev_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== tb/tb_move_to_front_recency_list_core.sv =====
`timescale 1ns / 100ps

module tb_move_to_front_recency_list_core;
  import mtf_pkg::*;

  localparam int unsigned DEPTH   = LIST_DEPTH_DEF;
  localparam int unsigned IDW     = IDENT_WIDTH_DEF;
  localparam int          LIMIT   = 300000;
  localparam int          IDLE_PC = 27;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] position;
    logic [CAP_W-1:0] count;
    logic             ev_valid;
    logic [IDW-1:0]   ev_ident;
  } recency_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  mtf_in_if  #(.IDENT_WIDTH(IDW)) in_ch ();
  mtf_out_if #(.IDENT_WIDTH(IDW)) out_ch ();

  move_to_front_recency_list_core #(
    .LIST_DEPTH (DEPTH),
    .IDENT_WIDTH(IDW)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_chan_i  (in_ch),
    .out_chan_o (out_ch)
  );

  // Shadow copy of the recency list and the capacity register.
  logic [IDW-1:0]   shadow_list [DEPTH];
  int               shadow_count;
  logic [CAP_W-1:0] shadow_cap;

  logic [IDW-1:0]   ident_backlog [$];
  recency_result_t  result_queue [$];

  bit burst_mode;
  int cycle_count;
  int words_sent;
  int results_seen;
  int hits_seen;
  int evictions_seen;
  int mismatches;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic recency_result_t record_ident(input logic [IDW-1:0] id);
    recency_result_t r;
    int              eff;
    int              pos;
    int              top;
    int              i;
    bit              found;
    r = '0;
    if (shadow_cap == 0) eff = 1;
    else if (shadow_cap > DEPTH) eff = DEPTH;
    else eff = shadow_cap;
    // A lowered capacity trims the tail silently on the next word.
    if (shadow_count > eff) shadow_count = eff;
    found = 1'b0;
    pos = 0;
    for (i = 0; i < shadow_count; i++) begin
      if (!found && shadow_list[i] == id) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      top = pos;
    end else if (shadow_count < eff) begin
      top = shadow_count;
      shadow_count++;
    end else begin
      top = eff - 1;
      r.ev_valid = 1'b1;
      r.ev_ident = shadow_list[top];
    end
    for (i = top; i > 0; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[0] = id;
    r.hit = found;
    r.position = pos[POS_W-1:0];
    r.count = shadow_count[CAP_W-1:0];
    return r;
  endfunction

  task automatic check_result();
    recency_result_t got;
    recency_result_t want;
    got.hit      = out_ch.hit;
    got.position = out_ch.hit_position;
    got.count    = out_ch.entry_count;
    got.ev_valid = out_ch.evicted_valid;
    got.ev_ident = out_ch.evicted_ident;
    results_seen++;
    if (result_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result word with nothing pending: hit=%0b pos=%0d cnt=%0d ev=%0b/%h",
                 got.hit, got.position, got.count, got.ev_valid, got.ev_ident);
    end else begin
      want = result_queue.pop_front();
      if (want.hit) hits_seen++;
      if (want.ev_valid) evictions_seen++;
      if (got.hit !== want.hit || got.position !== want.position ||
          got.count !== want.count || got.ev_valid !== want.ev_valid ||
          got.ev_ident !== want.ev_ident) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d mismatch", results_seen);
          $display("  expected hit=%0b pos=%0d cnt=%0d ev=%0b/%h",
                   want.hit, want.position, want.count, want.ev_valid, want.ev_ident);
          $display("  actual   hit=%0b pos=%0d cnt=%0d ev=%0b/%h",
                   got.hit, got.position, got.count, got.ev_valid, got.ev_ident);
        end
      end
    end
  endtask

  // Driver: a word stays on the bus until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.ident <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        result_queue.push_back(record_ident(in_ch.ident));
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (ident_backlog.size() != 0 &&
            (burst_mode || $urandom_range(0, 99) >= IDLE_PC)) begin
          in_ch.valid <= 1'b1;
          in_ch.ident <= ident_backlog.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      out_ch.ready <= burst_mode || ($urandom_range(0, 99) >= IDLE_PC);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, result_queue.size());
      $display("** move_to_front_recency_list_core: FAILED **");
      $finish;
    end
  end

  // Sampled on the falling edge so that all clocked updates have settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (ident_backlog.size() != 0 || in_ch.valid || result_queue.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    shadow_cap = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random phase: mostly words from a pool a little larger than the capacity,
  // so that hits, moves and evictions all happen, plus some fresh noise.
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_words, input bit pause);
    logic [IDW-1:0] pool [$];
    int             eff;
    int             pool_size;
    int             i;
    eff = (cap == 0) ? 1 : ((cap > DEPTH) ? DEPTH : cap);
    pool_size = eff + $urandom_range(1, eff / 2 + 3);
    for (i = 0; i < pool_size; i++) pool.push_back($urandom);
    write_capacity(cap);
    for (i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 99) < 85)
        ident_backlog.push_back(pool[$urandom_range(0, pool_size - 1)]);
      else
        ident_backlog.push_back($urandom);
      // The sender holds off here until every pending result is back.
      if (pause && i == n_words / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] caps [9];
    int               p;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    burst_mode   = 1'b0;
    shadow_count = 0;
    shadow_cap   = CAP_RESET;
    foreach (shadow_list[k]) shadow_list[k] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extremes, a hit one behind the front, then fill to the reset capacity.
    ident_backlog.push_back('0);
    ident_backlog.push_back('1);
    ident_backlog.push_back('0);
    for (p = 0; p < 14; p++) ident_backlog.push_back(32'h5A00_0000 + p);
    // All ones now sits in the last place: hit at the back, then at the front.
    ident_backlog.push_back('1);
    ident_backlog.push_back('1);
    // Full list, new word: the oldest entry drops off.
    ident_backlog.push_back(32'h0F0F_F0F0);
    wait_drained();

    // Capacity cut below the count: trimmed entries are gone without a report.
    write_capacity(5'd3);
    ident_backlog.push_back(32'h5A00_0008);
    ident_backlog.push_back(32'h5A00_000D);
    wait_drained();

    // Zero capacity behaves as a single entry.
    write_capacity(5'd0);
    ident_backlog.push_back(32'h1234_5678);
    ident_backlog.push_back(32'h1234_5678);
    ident_backlog.push_back(32'h8765_4321);
    wait_drained();

    caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd8, 5'd12, 5'd2, 5'd0};
    caps[8] = CAP_W'($urandom_range(0, 31));
    for (p = 0; p < 9; p++) begin
      burst_mode = (p == 5);
      run_phase(caps[p], 220, p == 2);
    end
    burst_mode = 1'b0;

    repeat (10) @(negedge clk_i);
    if (result_queue.size() != 0) mismatches += result_queue.size();
    $display("Sent %0d identifiers over capacities 0..31, %0d results checked",
             words_sent, results_seen);
    $display("Saw %0d hits and %0d evictions, %0d mismatches",
             hits_seen, evictions_seen, mismatches);
    if (mismatches == 0) begin
      $display("** move_to_front_recency_list_core: PASSED **");
    end else begin
      $display("** move_to_front_recency_list_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mtf_pkg.sv
hdl/mtf_in_if.sv
hdl/mtf_out_if.sv
hdl/mtf_cell.sv
hdl/move_to_front_recency_list_core.sv
tb/tb_move_to_front_recency_list_core.sv
